// ===== design/rti_pkg.sv =====
// rti_pkg: shared widths, register indexes and types of the ray/triangle test
// no dependencies
package rti_pkg;

	// coordinate format, signed Q16.16
	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;

	// exact intermediate widths
	localparam int DIFF_W = COORD_W + 1;        // edge and offset vectors
	localparam int PROD_W = 2 * DIFF_W;         // one cross-product term
	localparam int CRS_W  = PROD_W + 1;         // cross-product component
	localparam int LO_W   = DIFF_W + 1;         // low split of a cross component
	localparam int HI_W   = CRS_W - LO_W;       // high split of a cross component
	localparam int PL_W   = DIFF_W + LO_W + 1;  // low partial product
	localparam int PH_W   = DIFF_W + HI_W;      // high partial product
	localparam int DOT_W  = DIFF_W + CRS_W + 2; // dot product with growth
	localparam int QUO_W  = 31;                 // distance bits
	localparam int REM_W  = DOT_W + QUO_W;      // divider remainder

	// configuration
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 32;
	localparam int EPS_W     = 32;
	localparam int MIND_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_X = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_Y = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_Z = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_DET_EPSILON = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST    = CFG_IDX_W'(7);

	localparam logic [EPS_W-1:0] DET_EPS_RESET = EPS_W'(28147498);
	localparam logic [QUO_W-1:0] DIST_MAX      = '1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [CRS_W-1:0]   crs_t;
	typedef logic signed [PL_W-1:0]    pl_t;
	typedef logic signed [PH_W-1:0]    ph_t;
	typedef logic signed [DOT_W-1:0]   dot_t;

	typedef struct {
		coord_t org [3];
		coord_t dir [3];
	} ray_t;

	typedef struct {
		dot_t det;
		dot_t un;
		dot_t vn;
		dot_t tn;
	} dots_t;

	typedef struct {
		logic pass;
		dot_t det;
		dot_t tn;
	} chk_t;

endpackage

// ===== design/rti_if.sv =====
// rti_if: valid/ready channels of the ray/triangle test
// depends on rti_pkg
interface rti_tri_if import rti_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t vert0_x;
	coord_t vert0_y;
	coord_t vert0_z;
	coord_t vert1_x;
	coord_t vert1_y;
	coord_t vert1_z;
	coord_t vert2_x;
	coord_t vert2_y;
	coord_t vert2_z;

	modport source (output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
		vert2_x, vert2_y, vert2_z, input ready);
	modport sink (input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
		vert2_x, vert2_y, vert2_z, output ready);
endinterface

interface rti_res_if import rti_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             hit;
	logic [QUO_W-1:0] distance;

	modport source (output valid, hit, distance, input ready);
	modport sink (input valid, hit, distance, output ready);
endinterface

interface rti_cfg_if import rti_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/rti_geom.sv =====
// rti_geom: edges, cross products and exact dot products, six stages
// depends on rti_pkg
module rti_geom import rti_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  coord_t v0 [3],
	input  coord_t v1 [3],
	input  coord_t v2 [3],
	input  ray_t   ray,
	output logic   out_valid,
	output dots_t  dots
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	diff_t e1_s1 [3], e2_s1 [3], s_s1 [3], d_s1 [3];
	diff_t e1_s2 [3], e2_s2 [3], s_s2 [3], d_s2 [3];
	diff_t e1_s3 [3], e2_s3 [3], s_s3 [3], d_s3 [3];
	prod_t hp_s2 [3][2], qp_s2 [3][2];
	crs_t  h_s3 [3], q_s3 [3];
	pl_t   pl_s4 [4][3];
	ph_t   ph_s4 [4][3];
	dot_t  p_s5 [4][3];
	dot_t  dot_s6 [4];

	diff_t dot_a [4][3];
	crs_t  dot_b [4][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// dot operand pairs: det = e1.h, un = s.h, vn = d.q, tn = e2.q
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dot_a[0][i] = e1_s3[i];
			dot_b[0][i] = h_s3[i];
			dot_a[1][i] = s_s3[i];
			dot_b[1][i] = h_s3[i];
			dot_a[2][i] = d_s3[i];
			dot_b[2][i] = q_s3[i];
			dot_a[3][i] = e2_s3[i];
			dot_b[3][i] = q_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				// stage 1: differences
				e1_s1[i] <= diff_t'(v1[i]) - diff_t'(v0[i]);
				e2_s1[i] <= diff_t'(v2[i]) - diff_t'(v0[i]);
				s_s1[i]  <= diff_t'(ray.org[i]) - diff_t'(v0[i]);
				d_s1[i]  <= diff_t'(ray.dir[i]);
				// stage 2: cross-product terms
				hp_s2[i][0] <= d_s1[(i+1)%3] * e2_s1[(i+2)%3];
				hp_s2[i][1] <= d_s1[(i+2)%3] * e2_s1[(i+1)%3];
				qp_s2[i][0] <= s_s1[(i+1)%3] * e1_s1[(i+2)%3];
				qp_s2[i][1] <= s_s1[(i+2)%3] * e1_s1[(i+1)%3];
				e1_s2[i] <= e1_s1[i];
				e2_s2[i] <= e2_s1[i];
				s_s2[i]  <= s_s1[i];
				d_s2[i]  <= d_s1[i];
				// stage 3: cross components
				h_s3[i]  <= crs_t'(hp_s2[i][0]) - crs_t'(hp_s2[i][1]);
				q_s3[i]  <= crs_t'(qp_s2[i][0]) - crs_t'(qp_s2[i][1]);
				e1_s3[i] <= e1_s2[i];
				e2_s3[i] <= e2_s2[i];
				s_s3[i]  <= s_s2[i];
				d_s3[i]  <= d_s2[i];
			end
			for (int n = 0; n < 4; n++) begin
				for (int i = 0; i < 3; i++) begin
					// stage 4: split products, cross component cut in two
					pl_s4[n][i] <= dot_a[n][i] * $signed({1'b0, dot_b[n][i][LO_W-1:0]});
					ph_s4[n][i] <= dot_a[n][i] * $signed(dot_b[n][i][CRS_W-1:LO_W]);
					// stage 5: recombine
					p_s5[n][i] <= (dot_t'(ph_s4[n][i]) <<< LO_W) + dot_t'(pl_s4[n][i]);
				end
				// stage 6: sum of three
				dot_s6[n] <= p_s5[n][0] + p_s5[n][1] + p_s5[n][2];
			end
		end
	end

	assign out_valid = vld_s6;
	assign dots.det  = dot_s6[0];
	assign dots.un   = dot_s6[1];
	assign dots.vn   = dot_s6[2];
	assign dots.tn   = dot_s6[3];

endmodule

// ===== design/rti_chk.sv =====
// rti_chk: sign normalization and the division-free barycentric tests, two stages
// depends on rti_pkg
module rti_chk import rti_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  dots_t            dots,
	input  logic [EPS_W-1:0] det_eps,
	output logic             out_valid,
	output chk_t             chk
);

	logic vld_s1, vld_s2;
	logic nz_s1;
	dot_t det_s1, un_s1, vn_s1, tn_s1;
	logic pass_s2;
	dot_t det_s2, tn_s2;

	logic                    neg;
	logic signed [DOT_W:0]   uv_sum;
	logic                    pass_c;

	assign neg = dots.det[DOT_W-1];

	always_comb begin
		uv_sum = (DOT_W+1)'(un_s1) + (DOT_W+1)'(vn_s1);
		pass_c = nz_s1
			&& (det_s1 >= $signed({{(DOT_W-EPS_W){1'b0}}, det_eps}))
			&& !un_s1[DOT_W-1] && (un_s1 <= det_s1)
			&& !vn_s1[DOT_W-1]
			&& (uv_sum <= (DOT_W+1)'(det_s1))
			&& !tn_s1[DOT_W-1] && (tn_s1 != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nz_s1   <= dots.det != '0;
			det_s1  <= neg ? -dots.det : dots.det;
			un_s1   <= neg ? -dots.un : dots.un;
			vn_s1   <= neg ? -dots.vn : dots.vn;
			tn_s1   <= neg ? -dots.tn : dots.tn;
			pass_s2 <= pass_c;
			det_s2  <= det_s1;
			tn_s2   <= tn_s1;
		end
	end

	assign out_valid = vld_s2;
	assign chk.pass  = pass_s2;
	assign chk.det   = det_s2;
	assign chk.tn    = tn_s2;

endmodule

// ===== design/rti_div.sv =====
// rti_div: pipelined restoring divide for the distance, one quotient bit per stage,
// followed by the min-distance test and the output register; depends on rti_pkg
module rti_div import rti_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  chk_t              chk,
	input  logic [MIND_W-1:0] min_dist,
	output logic              out_valid,
	output logic              hit,
	output logic [QUO_W-1:0]  distance
);

	logic             vld_s [QUO_W+1];
	logic             pass_s [QUO_W+1];
	logic             sat_s [QUO_W+1];
	logic [QUO_W-1:0] quo_s [QUO_W+1];
	logic [REM_W-1:0] rem_s [QUO_W];
	logic [DOT_W-1:0] det_s [QUO_W];

	logic             vld_q, hit_q;
	logic [QUO_W-1:0] dist_q;

	logic [REM_W-1:0] rem0, dsat;
	logic [QUO_W-1:0] quo_f;
	logic             hit_c;

	assign rem0 = REM_W'($unsigned(chk.tn)) << FRAC_BITS;
	assign dsat = REM_W'($unsigned(chk.det)) << QUO_W;

	// entry stage: saturation check and operand setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s[0] <= chk.pass;
			sat_s[0]  <= rem0 >= dsat;
			quo_s[0]  <= '0;
			rem_s[0]  <= rem0;
			det_s[0]  <= $unsigned(chk.det);
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_bit
		localparam int B = QUO_W - 1 - k;
		logic [REM_W-1:0] dsh;
		logic             ge;

		assign dsh = REM_W'(det_s[k]) << B;
		assign ge  = rem_s[k] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pass_s[k+1] <= pass_s[k];
				sat_s[k+1]  <= sat_s[k];
				quo_s[k+1]  <= quo_s[k] | (ge ? (QUO_W'(1) << B) : '0);
			end
		end

		if (k < QUO_W - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? (rem_s[k] - dsh) : rem_s[k];
					det_s[k+1] <= det_s[k];
				end
			end
		end
	end

	assign quo_f = sat_s[QUO_W] ? DIST_MAX : quo_s[QUO_W];
	assign hit_c = pass_s[QUO_W] && (quo_f > QUO_W'(min_dist));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q  <= hit_c;
			dist_q <= hit_c ? quo_f : '0;
		end
	end

	assign out_valid = vld_q;
	assign hit       = hit_q;
	assign distance  = dist_q;

endmodule

// ===== design/ray_triangle_intersect_core.sv =====
// ray_triangle_intersect_core: top level of the Moller-Trumbore ray/triangle test
// depends on rti_pkg, rti_if, rti_geom, rti_chk, rti_div
//
// Tests one ray, set through the configuration channel, against a stream of
// triangles. One triangle transfer gives one result transfer, in order. The
// block takes a triangle in every cycle in which the pipe is not stalled; each
// passes through 6 geometry stages, 2 test stages, 1 divide setup stage, 31
// quotient stages and the output register. All stages advance together on one
// enable that is high while the output register is empty or its result is
// being taken, so a stalled result holds the whole pipe and nothing is dropped
// or repeated. Products are exact: the edge, cross and dot products carry full
// width and the u, v, u+v tests compare numerators against the sign-corrected
// determinant. Only the distance is divided, truncated to unsigned Q15.16 and
// saturated at 2^31-1. Configuration is taken in every cycle and must only
// be written while no triangle is in flight; unknown register indexes are
// ignored.
module ray_triangle_intersect_core import rti_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	rti_cfg_if.sink  cfg,
	rti_tri_if.sink  triangle,
	rti_res_if.source result
);

	// configuration registers
	coord_t            org_q [3];
	coord_t            dir_q [3];
	logic [EPS_W-1:0]  eps_q;
	logic [MIND_W-1:0] mind_q;

	logic   en;
	ray_t   ray;
	coord_t v0 [3], v1 [3], v2 [3];

	logic  geom_valid, chk_valid;
	dots_t dots;
	chk_t  chk;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
				dir_q[i] <= '0;
			end
			eps_q  <= DET_EPS_RESET;
			mind_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ORIGIN_X:    org_q[0] <= coord_t'(cfg.data);
				REG_ORIGIN_Y:    org_q[1] <= coord_t'(cfg.data);
				REG_ORIGIN_Z:    org_q[2] <= coord_t'(cfg.data);
				REG_DIRECTION_X: dir_q[0] <= coord_t'(cfg.data);
				REG_DIRECTION_Y: dir_q[1] <= coord_t'(cfg.data);
				REG_DIRECTION_Z: dir_q[2] <= coord_t'(cfg.data);
				REG_DET_EPSILON: eps_q    <= cfg.data[EPS_W-1:0];
				REG_MIN_DIST:    mind_q   <= cfg.data[MIND_W-1:0];
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// pipeline advances while the output register can take a result
	assign en             = !result.valid || result.ready;
	assign triangle.ready = en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ray.org[i] = org_q[i];
			ray.dir[i] = dir_q[i];
		end
		v0[0] = triangle.vert0_x;
		v0[1] = triangle.vert0_y;
		v0[2] = triangle.vert0_z;
		v1[0] = triangle.vert1_x;
		v1[1] = triangle.vert1_y;
		v1[2] = triangle.vert1_z;
		v2[0] = triangle.vert2_x;
		v2[1] = triangle.vert2_y;
		v2[2] = triangle.vert2_z;
	end

	// edges, cross products and the four dot products
	rti_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (triangle.valid),
		.v0        (v0),
		.v1        (v1),
		.v2        (v2),
		.ray       (ray),
		.out_valid (geom_valid),
		.dots      (dots)
	);

	// determinant sign fix-up and inside/parallel tests
	rti_chk u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (geom_valid),
		.dots      (dots),
		.det_eps   (eps_q),
		.out_valid (chk_valid),
		.chk       (chk)
	);

	// distance divide, min-distance test and output register
	rti_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (chk_valid),
		.chk       (chk),
		.min_dist  (mind_q),
		.out_valid (result.valid),
		.hit       (result.hit),
		.distance  (result.distance)
	);

endmodule
